/* design/wtg_pkg.sv */
// Shared constants, types and the waveform table for the wavetable tone generator.
package wtg_pkg;

  // Audio and phase format
  localparam int unsigned SAMPLE_RATE   = 8000;
  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned TABLE_BITS    = $clog2(TABLE_ENTRIES);
  localparam int unsigned ACC_W         = FRACTION_BITS + 4;
  localparam int unsigned STEP_W        = FRACTION_BITS + 3;
  localparam int unsigned COUNT_W       = 20;
  localparam int unsigned FREQ_W        = 16;
  localparam int unsigned MS_W          = 16;
  localparam int unsigned WORD_W        = 32;

  // Request limits
  localparam int unsigned MAX_FREQ_HZ = 2000;
  localparam int unsigned MS_PER_S    = 1000;
  localparam int unsigned CLAMP_W     = $clog2(MAX_FREQ_HZ + 1);

  localparam longint unsigned STEP_MAX  = (64'd1 << STEP_W) - 64'd1;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_W) - 64'd1;

  // Step = freq * TABLE_ENTRIES * 2^FRACTION_BITS / SAMPLE_RATE, done as a
  // multiply by a rounded-up reciprocal; the shift keeps it exact for every
  // clamped frequency (2^shift exceeds max freq times the sample rate).
  localparam longint unsigned STEP_GAIN  = longint'(TABLE_ENTRIES) << FRACTION_BITS;
  localparam int unsigned     STEP_SHIFT = 27;
  localparam longint unsigned STEP_MUL   =
    ((STEP_GAIN << STEP_SHIFT) + longint'(SAMPLE_RATE) - 64'd1) / longint'(SAMPLE_RATE);
  localparam int unsigned     STEP_MUL_W  = $clog2(STEP_MUL + 64'd1);
  localparam int unsigned     STEP_PROD_W = CLAMP_W + STEP_MUL_W;

  // Count = ms * SAMPLE_RATE / 1000, same reciprocal scheme (2^26 > 65535 * 1000).
  localparam int unsigned     COUNT_SHIFT  = 26;
  localparam longint unsigned COUNT_MUL    =
    ((longint'(SAMPLE_RATE) << COUNT_SHIFT) + longint'(MS_PER_S) - 64'd1)
    / longint'(MS_PER_S);
  localparam int unsigned     COUNT_MUL_W  = $clog2(COUNT_MUL + 64'd1);
  localparam int unsigned     COUNT_PROD_W = MS_W + COUNT_MUL_W;

  // Item operation codes
  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // Tone setup handed from the setup logic to the core
  typedef struct packed {
    logic [STEP_W-1:0]  step;
    logic [COUNT_W-1:0] count;
  } setup_t;

  // Waveform table: one period of the tone
  function automatic logic [WORD_W-1:0] wave_word(input logic [TABLE_BITS-1:0] idx);
    logic [WORD_W-1:0] w;
    unique case (idx)
      4'd0:    w = 32'h6000_0000;
      4'd1:    w = 32'h7000_0000;
      4'd2:    w = 32'h8000_0000;
      4'd3:    w = 32'h9000_0000;
      4'd4:    w = 32'h9FFF_FFFF;
      4'd5:    w = 32'h9000_0000;
      4'd6:    w = 32'h8000_0000;
      4'd7:    w = 32'h7000_0000;
      4'd8:    w = 32'h6000_0000;
      4'd9:    w = 32'h5000_0000;
      4'd10:   w = 32'h4000_0000;
      4'd11:   w = 32'h3000_0000;
      4'd12:   w = 32'h2000_0000;
      4'd13:   w = 32'h3000_0000;
      4'd14:   w = 32'h4000_0000;
      4'd15:   w = 32'h5000_0000;
      default: w = 32'h6000_0000;
    endcase
    return w;
  endfunction

endpackage

/* design/wtg_ifs.sv */
// Valid/ready channel interfaces for request items and sample items.
interface wtg_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [wtg_pkg::FREQ_W-1:0]  tone_freq_hz;
  logic [wtg_pkg::MS_W-1:0]    duration_ms;

  modport source (output valid, output operation, output tone_freq_hz,
                  output duration_ms, input ready);
  modport sink   (input valid, input operation, input tone_freq_hz,
                  input duration_ms, output ready);
endinterface

interface wtg_out_if;
  logic                        valid;
  logic                        ready;
  logic [wtg_pkg::WORD_W-1:0]  sample_word;
  logic                        last_sample;

  modport source (output valid, output sample_word, output last_sample, input ready);
  modport sink   (input valid, input sample_word, input last_sample, output ready);
endinterface

/* design/wavetable_tone_generator_top.sv */
// Wavetable tone generator: a start item (operation 0) clamps the frequency to
// 2000 Hz, clears the phase and loads the phase step and the sample count
// (duration in ms times the sample rate over 1000); it gives no result. Each
// tick item (operation 1) stands for one free audio FIFO slot and, while samples
// remain, gives one 32-bit table word for the current phase, with last_sample
// set on the final one; a tick with no samples left gives nothing. A new start
// drops any tone in progress. The block takes one item per clock cycle; a
// sample appears on the output in the cycle after its tick and sits in a single
// output register, so input is held off only in a cycle where that register is
// full and the output side is not ready.
module wavetable_tone_generator_top (
  input logic       clk,
  input logic       rst_n,
  wtg_in_if.sink    in_ch,
  wtg_out_if.source out_ch
);
  import wtg_pkg::*;

  setup_t setup;

  // Derive step and count from the request fields
  wtg_setup u_setup (
    .freq_hz (in_ch.tone_freq_hz),
    .dur_ms  (in_ch.duration_ms),
    .setup   (setup)
  );

  // Run the oscillator and hold each sample
  wtg_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_operation    (in_ch.operation),
    .in_setup        (setup),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_sample_word (out_ch.sample_word),
    .out_last_sample (out_ch.last_sample)
  );

endmodule

/* design/wtg_setup.sv */
// Tone setup: clamp frequency, derive phase step and sample count.
module wtg_setup (
  input  logic [wtg_pkg::FREQ_W-1:0] freq_hz,
  input  logic [wtg_pkg::MS_W-1:0]   dur_ms,
  output wtg_pkg::setup_t            setup
);
  import wtg_pkg::*;

  logic [CLAMP_W-1:0]      freq_clamped;
  logic [STEP_PROD_W-1:0]  step_prod;
  logic [STEP_PROD_W-1:0]  step_quot;
  logic [COUNT_PROD_W-1:0] count_prod;
  logic [COUNT_PROD_W-1:0] count_quot;

  // Clamp the requested frequency
  assign freq_clamped = (freq_hz > FREQ_W'(MAX_FREQ_HZ)) ? CLAMP_W'(MAX_FREQ_HZ)
                                                          : freq_hz[CLAMP_W-1:0];

  // Divide by the sample rate via reciprocal multiply
  assign step_prod = STEP_PROD_W'(freq_clamped) * STEP_PROD_W'(STEP_MUL);
  assign step_quot = step_prod >> STEP_SHIFT;

  // Divide by milliseconds per second via reciprocal multiply
  assign count_prod = COUNT_PROD_W'(dur_ms) * COUNT_PROD_W'(COUNT_MUL);
  assign count_quot = count_prod >> COUNT_SHIFT;

  // Saturate both to their register widths
  always_comb begin
    if (step_quot > STEP_PROD_W'(STEP_MAX)) begin
      setup.step = STEP_W'(STEP_MAX);
    end else begin
      setup.step = step_quot[STEP_W-1:0];
    end
    if (count_quot > COUNT_PROD_W'(COUNT_MAX)) begin
      setup.count = COUNT_W'(COUNT_MAX);
    end else begin
      setup.count = count_quot[COUNT_W-1:0];
    end
  end

endmodule

/* design/wtg_core.sv */
// Phase accumulator, sample countdown, table lookup and output register.
module wtg_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  wtg_pkg::setup_t             in_setup,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [wtg_pkg::WORD_W-1:0]  out_sample_word,
  output logic                        out_last_sample
);
  import wtg_pkg::*;

  logic [ACC_W-1:0]   phase_r,     phase_nxt;
  logic [STEP_W-1:0]  step_r,      step_nxt;
  logic [COUNT_W-1:0] left_r,      left_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  word_r,      word_nxt;
  logic               last_r,      last_nxt;
  logic               accept;
  logic               emit;

  // Take an item whenever the output register is empty or draining
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign emit     = accept && (op_t'(in_operation) == OP_TICK) && (left_r != '0);

  // Next state: start reloads the tone, a productive tick advances it
  always_comb begin
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r && !out_ready;
    word_nxt      = word_r;
    last_nxt      = last_r;
    if (accept && (op_t'(in_operation) == OP_START)) begin
      phase_nxt = '0;
      step_nxt  = in_setup.step;
      left_nxt  = in_setup.count;
    end
    if (emit) begin
      word_nxt      = wave_word(phase_r[FRACTION_BITS +: TABLE_BITS]);
      last_nxt      = (left_r == COUNT_W'(1));
      out_valid_nxt = 1'b1;
      phase_nxt     = phase_r + ACC_W'(step_r);
      left_nxt      = left_r - COUNT_W'(1);
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      step_r      <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the output payload
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_sample_word = word_r;
  assign out_last_sample = last_r;

endmodule
